// File: hw/rtl/aarm_pkg.sv
package aarm_pkg;

	localparam int CordicIter = 16;
	localparam int FracBits = 14;
	localparam int AtanEntries = 24;
	localparam int CW = 34;

	localparam logic signed [CW-1:0] InvGainQ30 = 34'sd652032874;
	localparam logic [24:0] RadPerUnitQ38 = 25'd18740330;
	localparam logic signed [17:0] HalfTurn = 18'sd46080;
	localparam logic signed [17:0] QuarterTurn = 18'sd23040;

	typedef logic signed [15:0] s16_t;

	typedef struct packed {
		s16_t w;
		s16_t x;
		s16_t y;
		s16_t z;
	} quat_t;

	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] z;
	} cordic_t;

	function automatic logic signed [CW-1:0] atan_q30(input int i);
		logic signed [CW-1:0] t [AtanEntries];
		t = '{34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
			34'sd67021686, 34'sd33543515, 34'sd16775850, 34'sd8388437,
			34'sd4194282, 34'sd2097149, 34'sd1048575, 34'sd524287,
			34'sd262143, 34'sd131071, 34'sd65535, 34'sd32767,
			34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
			34'sd1023, 34'sd511, 34'sd255, 34'sd127};
		return t[i];
	endfunction

	// round half up and saturate to 16 bits, value has s fraction bits to drop
	function automatic s16_t rnd_sat(input logic signed [63:0] v, input int s);
		logic signed [63:0] r;
		r = (s == 0) ? v : ((v + (64'sd1 <<< (s - 1))) >>> s);
		if (r > 64'sd32767)
			return 16'sh7fff;
		else if (r < -64'sd32768)
			return 16'sh8000;
		else
			return r[15:0];
	endfunction

endpackage

// File: hw/rtl/aarm_cordic.sv
module aarm_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic signed [33:0] in_rad,
	input  logic              in_neg,
	input  logic [47:0]       in_axis,
	output logic              out_valid,
	output aarm_pkg::cordic_t out_c,
	output logic              out_neg,
	output logic [47:0]       out_axis
);
	import aarm_pkg::*;

	logic    vld_s [CordicIter+1];
	cordic_t c_s   [CordicIter+1];
	logic    neg_s [CordicIter+1];
	logic [47:0] ax_s [CordicIter+1];

	assign vld_s[0] = in_valid;
	assign c_s[0] = '{cx: InvGainQ30, sy: '0, z: in_rad};
	assign neg_s[0] = in_neg;
	assign ax_s[0] = in_axis;

	// one micro-rotation per stage
	for (genvar i = 0; i < CordicIter; i++) begin : g_it
		cordic_t nx;
		always_comb begin
			logic signed [CW-1:0] dx, dy;
			dx = c_s[i].sy >>> i;
			dy = c_s[i].cx >>> i;
			if (c_s[i].z >= 0) begin
				nx.cx = c_s[i].cx - dx;
				nx.sy = c_s[i].sy + dy;
				nx.z  = c_s[i].z - atan_q30(i);
			end else begin
				nx.cx = c_s[i].cx + dx;
				nx.sy = c_s[i].sy - dy;
				nx.z  = c_s[i].z + atan_q30(i);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				c_s[i+1] <= nx;
				neg_s[i+1] <= neg_s[i];
				ax_s[i+1] <= ax_s[i];
			end
		end
	end

	assign out_valid = vld_s[CordicIter];
	assign out_c = c_s[CordicIter];
	assign out_neg = neg_s[CordicIter];
	assign out_axis = ax_s[CordicIter];
endmodule

// File: hw/rtl/axis_angle_to_rotation_matrix_top.sv
// throughput: one input transaction per three row transactions on the single
// output channel; the pipeline advances each cycle unless the output row
// sequencer is holding a matrix
// reset: arst_n clears all valid bits and the row counter asynchronously
module axis_angle_to_rotation_matrix_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// axis_x[15:0], axis_y[31:16], axis_z[47:32], angle_deg[64:48], zero pad
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// col0[15:0] col1[31:16] col2[47:32] quat_w[63:48] quat_x[79:64]
	// quat_y[95:80] quat_z[111:96]
	output logic [111:0] m_axis_tdata,
	// row_index[1:0]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);
	import aarm_pkg::*;

	logic en;

	// stage 1: angle wrap and fold
	logic vld_s1, neg_s1;
	logic signed [17:0] a_s1;
	logic [47:0] ax_s1;
	logic signed [17:0] a_in, a_w, a_f;
	logic neg_in;
	always_comb begin
		a_in = {s_axis_tdata[64], s_axis_tdata[64:48]};
		a_w = a_in;
		if (a_in > HalfTurn) a_w = a_in - (HalfTurn <<< 1);
		else if (a_in <= -HalfTurn) a_w = a_in + (HalfTurn <<< 1);
		a_f = a_w;
		neg_in = 1'b0;
		if (a_w > QuarterTurn) begin
			a_f = a_w - HalfTurn; neg_in = 1'b1;
		end else if (a_w < -QuarterTurn) begin
			a_f = a_w + HalfTurn; neg_in = 1'b1;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a_f; neg_s1 <= neg_in; ax_s1 <= s_axis_tdata[47:0];
		end
	end

	// stage 2: degrees to radians q30
	logic vld_s2, neg_s2;
	logic signed [33:0] rad_s2;
	logic [47:0] ax_s2;
	logic [16:0] mag;
	logic [41:0] prod;
	logic [33:0] radm;
	always_comb begin
		mag = a_s1[17] ? 17'(-a_s1) : a_s1[16:0];
		prod = 42'(mag) * 42'(RadPerUnitQ38) + 42'd128;
		radm = prod[41:8];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2 <= a_s1[17] ? -$signed(radm) : $signed(radm);
			neg_s2 <= neg_s1; ax_s2 <= ax_s1;
		end
	end

	logic c_vld, c_neg;
	cordic_t c_out;
	logic [47:0] c_ax;
	aarm_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s2), .in_rad(rad_s2), .in_neg(neg_s2), .in_axis(ax_s2),
		.out_valid(c_vld), .out_c(c_out), .out_neg(c_neg), .out_axis(c_ax)
	);

	// stage 3: negate, cosine to w, axis times sine
	logic vld_s3;
	s16_t w_s3;
	logic signed [49:0] px_s3, py_s3, pz_s3;
	logic signed [CW-1:0] cxn, syn;
	assign cxn = c_neg ? -c_out.cx : c_out.cx;
	assign syn = c_neg ? -c_out.sy : c_out.sy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= c_vld;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			w_s3 <= rnd_sat(64'(cxn), 30 - FracBits);
			px_s3 <= $signed(c_ax[15:0]) * syn;
			py_s3 <= $signed(c_ax[31:16]) * syn;
			pz_s3 <= $signed(c_ax[47:32]) * syn;
		end
	end

	// stage 4: quaternion rounding
	logic vld_s4;
	quat_t q_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q_s4.w <= w_s3;
			q_s4.x <= rnd_sat(64'(px_s3), 44 - FracBits);
			q_s4.y <= rnd_sat(64'(py_s3), 44 - FracBits);
			q_s4.z <= rnd_sat(64'(pz_s3), 44 - FracBits);
		end
	end

	// stage 5: pairwise products
	logic vld_s5;
	quat_t q_s5;
	logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q_s5 <= q_s4;
			xx <= q_s4.x * q_s4.x; yy <= q_s4.y * q_s4.y; zz <= q_s4.z * q_s4.z;
			xy <= q_s4.x * q_s4.y; xz <= q_s4.x * q_s4.z; yz <= q_s4.y * q_s4.z;
			wx <= q_s4.w * q_s4.x; wy <= q_s4.w * q_s4.y; wz <= q_s4.w * q_s4.z;
		end
	end

	// stage 6: matrix entries, held while rows go out
	logic vld_s6;
	quat_t q_s6;
	s16_t m_s6 [9];
	logic [1:0] row_q;
	localparam logic signed [63:0] One = 64'sd1 <<< (2 * FracBits);
	function automatic s16_t ent(input logic signed [63:0] v);
		return rnd_sat(v, FracBits);
	endfunction
	logic last_take;
	assign last_take = vld_s6 && m_axis_tready && row_q == 2'd2;
	assign en = !vld_s6 || last_take;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0; row_q <= 2'd0;
		end else begin
			if (en) vld_s6 <= vld_s5;
			if (vld_s6 && m_axis_tready) row_q <= (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q_s6 <= q_s5;
			m_s6[0] <= ent(One - 2 * (64'(yy) + 64'(zz)));
			m_s6[1] <= ent(2 * (64'(xy) - 64'(wz)));
			m_s6[2] <= ent(2 * (64'(xz) + 64'(wy)));
			m_s6[3] <= ent(2 * (64'(xy) + 64'(wz)));
			m_s6[4] <= ent(One - 2 * (64'(xx) + 64'(zz)));
			m_s6[5] <= ent(2 * (64'(yz) - 64'(wx)));
			m_s6[6] <= ent(2 * (64'(xz) - 64'(wy)));
			m_s6[7] <= ent(2 * (64'(yz) + 64'(wx)));
			m_s6[8] <= ent(One - 2 * (64'(xx) + 64'(yy)));
		end
	end

	// output row select
	s16_t c0, c1, c2;
	always_comb begin
		case (row_q)
			2'd0: begin c0 = m_s6[0]; c1 = m_s6[1]; c2 = m_s6[2]; end
			2'd1: begin c0 = m_s6[3]; c1 = m_s6[4]; c2 = m_s6[5]; end
			default: begin c0 = m_s6[6]; c1 = m_s6[7]; c2 = m_s6[8]; end
		endcase
	end
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s6;
	assign m_axis_tdata = {q_s6.z, q_s6.y, q_s6.x, q_s6.w, c2, c1, c0};
	assign m_axis_tuser = row_q;
	assign m_axis_tlast = row_q == 2'd2;

	// row counter stays in range and only moves on a transaction
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q != 2'd3) else $error("row counter out of range");
	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(row_q))
		else $error("row moved without transaction");
	a_no_accept_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s6 && row_q != 2'd2) |-> !s_axis_tready)
		else $error("pipeline advanced mid matrix");
endmodule

// File: test/axis_angle_to_rotation_matrix_top_tb.sv
`timescale 1ns / 1ps

module axis_angle_to_rotation_matrix_top_tb;
	import aarm_pkg::*;

	typedef struct {
		logic [1:0]  row;
		logic [15:0] c0, c1, c2, qw, qx, qy, qz;
		logic        last;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [71:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [111:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;

	row_t   expected_rows[$];
	int     mismatch_count = 0;
	bit     stall_enable = 1;
	int     hold_cycles = 0;

	axis_angle_to_rotation_matrix_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// floor division by 2^s
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_sat(longint v, int s);
		longint r;
		r = (s == 0) ? v : floor_shift(v + (64'sd1 <<< (s - 1)), s);
		if (r > 32767)
			r = 32767;
		else if (r < -32768)
			r = -32768;
		return r;
	endfunction

	// cordic sine/cosine of the half angle, quaternion, and matrix rows
	task automatic predict_rotation_rows(input logic [71:0] item);
		longint ax, ay, az, a, mag, rad, cx, sy, zr, dx, dy, w, qx, qy, qz, one;
		longint m[9];
		longint atan_tab[24];
		bit negate;
		row_t r;
		atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
			262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
			255, 127};
		ax = $signed(item[15:0]);
		ay = $signed(item[31:16]);
		az = $signed(item[47:32]);
		a = $signed(item[64:48]);
		negate = 0;
		if (a > 46080)
			a -= 92160;
		else if (a <= -46080)
			a += 92160;
		if (a > 23040) begin
			a -= 46080;
			negate = 1;
		end else if (a < -23040) begin
			a += 46080;
			negate = 1;
		end
		mag = a < 0 ? -a : a;
		rad = (mag * 18740330 + 128) >>> 8;
		if (a < 0)
			rad = -rad;
		cx = 652032874;
		sy = 0;
		zr = rad;
		for (int i = 0; i < CordicIter && i < 24; i++) begin
			dx = floor_shift(sy, i);
			dy = floor_shift(cx, i);
			if (zr >= 0) begin
				cx -= dx;
				sy += dy;
				zr -= atan_tab[i];
			end else begin
				cx += dx;
				sy -= dy;
				zr += atan_tab[i];
			end
		end
		if (negate) begin
			cx = -cx;
			sy = -sy;
		end
		w = round_sat(cx, 30 - FracBits);
		qx = round_sat(ax * sy, 44 - FracBits);
		qy = round_sat(ay * sy, 44 - FracBits);
		qz = round_sat(az * sy, 44 - FracBits);
		one = 64'sd1 <<< (2 * FracBits);
		m[0] = one - 2 * (qy * qy + qz * qz);
		m[1] = 2 * (qx * qy - w * qz);
		m[2] = 2 * (qx * qz + w * qy);
		m[3] = 2 * (qx * qy + w * qz);
		m[4] = one - 2 * (qx * qx + qz * qz);
		m[5] = 2 * (qy * qz - w * qx);
		m[6] = 2 * (qx * qz - w * qy);
		m[7] = 2 * (qy * qz + w * qx);
		m[8] = one - 2 * (qx * qx + qy * qy);
		for (int k = 0; k < 3; k++) begin
			r.row = k[1:0];
			r.c0 = 16'(round_sat(m[k * 3], FracBits));
			r.c1 = 16'(round_sat(m[k * 3 + 1], FracBits));
			r.c2 = 16'(round_sat(m[k * 3 + 2], FracBits));
			r.qw = 16'(w);
			r.qx = 16'(qx);
			r.qy = 16'(qy);
			r.qz = 16'(qz);
			r.last = (k == 2);
			expected_rows.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		mismatch_count++;
	endtask

	// send one transaction, sometimes with a random gap before it
	task automatic send_item(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic [16:0] ang);
		int gap;
		logic [71:0] item;
		item = {7'd0, ang, z, y, x};
		if (stall_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= item;
		predict_rotation_rows(item);
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	function automatic logic [16:0] random_angle();
		return 17'($signed($urandom_range(0, 92160)) - 46080);
	endfunction

	// receiver readiness: random stall bursts and one long hold-off
	initial begin
		int burst;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles--;
			end else if (stall_enable && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 16);
				m_axis_tready <= 1'b0;
				repeat (burst - 1) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// check each row transaction against the oldest expectation
	always @(posedge clk) begin
		row_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_rows.size() == 0) begin
				report_mismatch("unexpected row", {14'd0, m_axis_tuser}, 16'd0);
			end else begin
				e = expected_rows.pop_front();
				if (m_axis_tuser !== e.row)
					report_mismatch("row_index", {14'd0, m_axis_tuser}, {14'd0, e.row});
				if (m_axis_tdata[15:0] !== e.c0)
					report_mismatch("col0", m_axis_tdata[15:0], e.c0);
				if (m_axis_tdata[31:16] !== e.c1)
					report_mismatch("col1", m_axis_tdata[31:16], e.c1);
				if (m_axis_tdata[47:32] !== e.c2)
					report_mismatch("col2", m_axis_tdata[47:32], e.c2);
				if (m_axis_tdata[63:48] !== e.qw)
					report_mismatch("quat_w", m_axis_tdata[63:48], e.qw);
				if (m_axis_tdata[79:64] !== e.qx)
					report_mismatch("quat_x", m_axis_tdata[79:64], e.qx);
				if (m_axis_tdata[95:80] !== e.qy)
					report_mismatch("quat_y", m_axis_tdata[95:80], e.qy);
				if (m_axis_tdata[111:96] !== e.qz)
					report_mismatch("quat_z", m_axis_tdata[111:96], e.qz);
				if (m_axis_tlast !== e.last)
					report_mismatch("last_row", {15'd0, m_axis_tlast}, {15'd0, e.last});
			end
		end
	end

	// axis extremes and angle wrap and quadrant cases
	task automatic test_directed();
		logic [16:0] angs[10];
		angs = '{17'd0, 17'd46080, -17'sd46080, 17'd23040, -17'sd23040, 17'd23041,
			-17'sd23041, 17'd46079, 17'd11520, -17'sd1};
		foreach (angs[i])
			send_item(16'h4000, 16'h0000, 16'h0000, angs[i]);
		send_item(16'h7fff, 16'h7fff, 16'h7fff, 17'd23040);
		send_item(16'h8000, 16'h8000, 16'h8000, 17'd23040);
		send_item(16'h8000, 16'h7fff, 16'h0000, 17'd11520);
		send_item(16'h2d41, 16'h2d41, 16'h0000, 17'd30000);
		send_item(16'h24f3, 16'h24f3, 16'h24f3, -17'sd30000);
		send_item(16'hffff, 16'h0001, 16'haaaa, 17'd46080);
		send_item(16'h5555, 16'hffff, 16'h0000, 17'd100);
		send_item(16'h0000, 16'h0000, 16'h4000, 17'd34560);
	endtask

	// random axes: mostly unit-ish, some full range
	task automatic test_random(input int count);
		logic [15:0] x, y, z;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 3) == 0) begin
				x = 16'($urandom);
				y = 16'($urandom);
				z = 16'($urandom);
			end else begin
				x = 16'($signed($urandom_range(0, 18918)) - 9459);
				y = 16'($signed($urandom_range(0, 18918)) - 9459);
				z = 16'($signed($urandom_range(0, 18918)) - 9459);
			end
			send_item(x, y, z, random_angle());
		end
	endtask

	// long output hold-off while the sender keeps offering
	task automatic test_backpressure();
		hold_cycles = 200;
		test_random(30);
	endtask

	// stream with no idling on either side
	task automatic test_full_rate();
		stall_enable = 0;
		test_random(60);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(340);
		test_backpressure();
		test_full_rate();
		s_axis_tvalid <= 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (CordicIter + 20) @(posedge clk);
		if (mismatch_count == 0 && expected_rows.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("FAILURE");
		$finish;
	end

endmodule
